// ----- src/pbm_pkg.sv -----
package pbm_pkg;

  // Register map (word index = paddr[3:2])
  localparam int unsigned RegAddrW = 4;
  localparam logic [1:0] REG_HOLD_TIME      = 2'd0;
  localparam logic [1:0] REG_BATTERY_PERIOD = 2'd1;
  localparam logic [1:0] REG_STATUS_PERIOD  = 2'd2;

  // Reset values of the configuration registers
  localparam logic [15:0] HoldTimeRst      = 16'd3000;
  localparam logic [15:0] BatteryPeriodRst = 16'd10000;
  localparam logic [15:0] StatusPeriodRst  = 16'd500;

  // Charger status byte layout
  localparam int unsigned StUsbBit = 2;
  localparam int unsigned StChgLo  = 4;

  // Battery sample limits
  localparam logic [11:0] AdcMinMv = 12'd250;
  localparam logic [11:0] AdcMaxMv = 12'd2800;
  localparam logic [12:0] BatMinMv = 13'd2800;
  localparam logic [12:0] BatMaxMv = 13'd4400;
  localparam logic [2:0]  BadLimit = 3'd5;

  localparam logic [6:0] PctFull = 7'd100;

  // Hold divider: dividend = held * 100 with held < 2^16, quotient < 128
  localparam int unsigned DivNumW = 23;
  localparam int unsigned DivDenW = 16;
  localparam int unsigned DivQW   = 7;

  typedef enum logic [1:0] {
    EV_NONE        = 2'd0,
    EV_SHUTDOWN    = 2'd1,
    EV_USB_BLOCKED = 2'd2
  } event_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_DIV,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [15:0] hold_time_ms;
    logic [15:0] sample_period_ms;
    logic [15:0] status_period_ms;
  } cfg_t;

  typedef struct packed {
    logic               start;
    logic [DivNumW-1:0] dividend;
    logic [DivDenW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DivQW-1:0] quotient;
  } div_rsp_t;

  // Charge percent step table
  function automatic logic [6:0] volts_to_percent(input logic [12:0] mv);
    logic [6:0] pct;
    if (mv >= 13'd4200)      pct = 7'd100;
    else if (mv >= 13'd4100) pct = 7'd90;
    else if (mv >= 13'd4000) pct = 7'd80;
    else if (mv >= 13'd3900) pct = 7'd65;
    else if (mv >= 13'd3800) pct = 7'd50;
    else if (mv >= 13'd3700) pct = 7'd35;
    else if (mv >= 13'd3600) pct = 7'd20;
    else if (mv >= 13'd3500) pct = 7'd10;
    else if (mv >= 13'd3400) pct = 7'd5;
    else                     pct = 7'd0;
    return pct;
  endfunction

endpackage

// ----- src/pbm_cfg_regs.sv -----
module pbm_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pbm_pkg::RegAddrW-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output pbm_pkg::cfg_t                 cfg_o
);
  import pbm_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] idx;

  assign idx    = paddr[3:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hold_time_ms     <= HoldTimeRst;
      cfg_q.sample_period_ms <= BatteryPeriodRst;
      cfg_q.status_period_ms <= StatusPeriodRst;
    end else if (wr_en) begin
      case (idx)
        REG_HOLD_TIME:      cfg_q.hold_time_ms     <= pwdata[15:0];
        REG_BATTERY_PERIOD: cfg_q.sample_period_ms <= pwdata[15:0];
        REG_STATUS_PERIOD:  cfg_q.status_period_ms <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_HOLD_TIME:      prdata = {16'd0, cfg_q.hold_time_ms};
      REG_BATTERY_PERIOD: prdata = {16'd0, cfg_q.sample_period_ms};
      REG_STATUS_PERIOD:  prdata = {16'd0, cfg_q.status_period_ms};
      default:            prdata = 32'd0;
    endcase
  end

endmodule

// ----- src/pbm_divider.sv -----
module pbm_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pbm_pkg::div_req_t req_i,
  output pbm_pkg::div_rsp_t rsp_o
);
  import pbm_pkg::*;

  // restoring divider, one quotient bit per cycle; needs dividend < divisor << DivQW
  logic [DivDenW-1:0] rem_q, rem_d;
  logic [DivQW-1:0]   num_q, num_d;
  logic [DivDenW-1:0] den_q;
  logic [2:0]         cnt_q, cnt_d;
  logic               done_q, done_d;
  logic [DivDenW:0]   trial;
  logic               fits;

  assign trial = {rem_q, num_q[DivQW-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    num_d  = num_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d = req_i.dividend[DivNumW-1:DivQW];
      num_d = req_i.dividend[DivQW-1:0];
      cnt_d = 3'(DivQW);
    end else if (cnt_q != 3'd0) begin
      rem_d  = fits ? DivDenW'(trial - {1'b0, den_q}) : trial[DivDenW-1:0];
      num_d  = {num_q[DivQW-2:0], fits};
      cnt_d  = cnt_q - 3'd1;
      done_d = (cnt_q == 3'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // operands
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    if (req_i.start) den_q <= req_i.divisor;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = num_q;

endmodule

// ----- src/power_button_battery_monitor.sv -----
// Power button and battery monitor. One input beat is one poll tick; each tick
// yields exactly one result beat. A tick skips S_DIV when the button is up or
// the hold has reached hold_time_ms, and passes through it while a hold is in
// progress, where hold percent comes from a 7-step restoring divider (one
// quotient bit per cycle); in_ready_o is high only while the sequencer is idle.
// A result waiting in the output register holds the sequencer in its final
// state until taken. Configuration is through the APB port: hold_time_ms at
// 0x0, sample_period_ms at 0x4, status_period_ms at 0x8, 16 bits each.
module power_button_battery_monitor (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pbm_pkg::RegAddrW-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  // tick input
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [31:0]                  now_ms_i,
  input  logic                         button_down_i,
  input  logic                         refresh_i,
  input  logic                         status_read_ok_i,
  input  logic [7:0]                   status_byte_i,
  input  logic                         battery_read_ok_i,
  input  logic [11:0]                  battery_adc_mv_i,
  // result output
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   event_kind_o,
  output logic [6:0]                   hold_progress_o,
  output logic                         button_pressed_o,
  output logic                         usb_attached_o,
  output logic                         charging_o,
  output logic                         status_ok_o,
  output logic [7:0]                   charger_status_o,
  output logic [12:0]                  pack_mv_o,
  output logic [6:0]                   pack_charge_pct_o,
  output logic                         pack_trusted_o,
  output logic [31:0]                  error_count_o,
  output logic [31:0]                  sequence_res_o
);
  import pbm_pkg::*;

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  pbm_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pbm_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  state_e state_q, state_d;

  // latched tick
  logic [31:0] now_q;
  logic        down_q, refresh_q, st_ok_q, bat_ok_q;
  logic [7:0]  st_byte_q;
  logic [11:0] adc_q;

  // monitor state
  logic        press_active_q, press_active_d;
  logic [31:0] press_start_q, press_start_d;
  logic        event_done_q, event_done_d;
  logic [31:0] last_status_q, last_status_d;
  logic [31:0] last_battery_q, last_battery_d;
  logic [2:0]  bad_cnt_q, bad_cnt_d;
  logic [31:0] fail_cnt_q, fail_cnt_d;
  logic [31:0] tick_cnt_q;
  logic [7:0]  held_status_q, held_status_d;
  logic        usb_q, usb_d, chg_q, chg_d, ok_q, ok_d, batt_q, batt_d;
  logic [12:0] volts_q, volts_d;
  logic [6:0]  pct_held_q, pct_held_d;

  // per-tick results
  event_e      event_q, event_d;
  logic [6:0]  hold_pct_q;

  // output register
  logic        out_valid_q;
  logic [1:0]  o_event_q;
  logic [6:0]  o_hold_q, o_bpct_q;
  logic        o_down_q, o_usb_q, o_chg_q, o_ok_q, o_batt_q;
  logic [7:0]  o_status_q;
  logic [12:0] o_mv_q;
  logic [31:0] o_err_q, o_seq_q;

  // sequencer controls
  logic in_accept, calc_en, out_load;

  // tick arithmetic
  logic [31:0] start_ms, held;
  logic        hold_reached, fire_event, poll, sample, bat_good;
  logic [12:0] bmv;
  logic [1:0]  chg_state;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_CALC;
      S_CALC: state_d = div_req.start ? S_DIV : S_DONE;
      S_DIV:  if (div_rsp.done) state_d = S_DONE;
      S_DONE: if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o = 1'b0;
    calc_en    = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      S_IDLE: in_ready_o = 1'b1;
      S_CALC: calc_en    = 1'b1;
      S_DIV:  ;
      S_DONE: out_load   = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  assign in_accept = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  // input latch
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      now_q     <= now_ms_i;
      down_q    <= button_down_i;
      refresh_q <= refresh_i;
      st_ok_q   <= status_read_ok_i;
      st_byte_q <= status_byte_i;
      bat_ok_q  <= battery_read_ok_i;
      adc_q     <= battery_adc_mv_i;
    end
  end

  // hold timing and poll decisions
  assign start_ms     = press_active_q ? press_start_q : now_q;
  assign held         = now_q - start_ms;
  assign hold_reached = held >= {16'd0, cfg.hold_time_ms};
  assign fire_event   = down_q && !event_done_q && hold_reached;
  assign poll   = refresh_q || ((now_q - last_status_q) >= {16'd0, cfg.status_period_ms});
  assign sample = (now_q - last_battery_q) >= {16'd0, cfg.sample_period_ms};
  assign bmv       = {adc_q, 1'b0};
  assign bat_good  = bat_ok_q && adc_q >= AdcMinMv && adc_q <= AdcMaxMv &&
                     bmv >= BatMinMv && bmv <= BatMaxMv;
  assign chg_state = st_byte_q[StChgLo+1:StChgLo];

  // divider request: hold in progress, so held < hold_time_ms < 2^16
  assign div_req.start    = calc_en && down_q && !hold_reached;
  assign div_req.dividend = DivNumW'(held[15:0]) * DivNumW'(PctFull);
  assign div_req.divisor  = cfg.hold_time_ms;

  // state update for one tick, in the order press, status poll, battery
  always_comb begin
    press_active_d = press_active_q;
    press_start_d  = press_start_q;
    event_done_d   = event_done_q;
    last_status_d  = last_status_q;
    last_battery_d = last_battery_q;
    bad_cnt_d      = bad_cnt_q;
    fail_cnt_d     = fail_cnt_q;
    held_status_d  = held_status_q;
    usb_d          = usb_q;
    chg_d          = chg_q;
    ok_d           = ok_q;
    batt_d         = batt_q;
    volts_d        = volts_q;
    pct_held_d     = pct_held_q;
    event_d        = EV_NONE;

    if (down_q) begin
      press_active_d = 1'b1;
      press_start_d  = start_ms;
      if (fire_event) begin
        if (st_ok_q) begin
          held_status_d = st_byte_q;
          usb_d         = st_byte_q[StUsbBit];
        end
        event_d      = usb_d ? EV_USB_BLOCKED : EV_SHUTDOWN;
        event_done_d = 1'b1;
      end
    end else begin
      press_active_d = 1'b0;
      press_start_d  = '0;
      event_done_d   = 1'b0;
    end

    if (poll) begin
      last_status_d = now_q;
      if (st_ok_q) begin
        held_status_d = st_byte_q;
        usb_d         = st_byte_q[StUsbBit];
        chg_d         = (chg_state == 2'd1) || (chg_state == 2'd2);
        ok_d          = 1'b1;
      end else begin
        fail_cnt_d = fail_cnt_q + 32'd1;
        ok_d       = 1'b0;
      end
    end

    if (sample) begin
      last_battery_d = now_q;
      if (bat_good) begin
        volts_d    = bmv;
        pct_held_d = volts_to_percent(bmv);
        batt_d     = 1'b1;
        bad_cnt_d  = '0;
      end else begin
        if (bad_cnt_q < BadLimit) bad_cnt_d = bad_cnt_q + 3'd1;
        if (bad_cnt_d >= BadLimit) batt_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_active_q <= 1'b0;
      press_start_q  <= '0;
      event_done_q   <= 1'b0;
      last_status_q  <= '0;
      last_battery_q <= '0;
      bad_cnt_q      <= '0;
      fail_cnt_q     <= '0;
      tick_cnt_q     <= '0;
      held_status_q  <= '0;
      usb_q          <= 1'b0;
      chg_q          <= 1'b0;
      ok_q           <= 1'b0;
      batt_q         <= 1'b0;
      volts_q        <= '0;
      pct_held_q     <= '0;
    end else begin
      if (calc_en) begin
        press_active_q <= press_active_d;
        press_start_q  <= press_start_d;
        event_done_q   <= event_done_d;
        last_status_q  <= last_status_d;
        last_battery_q <= last_battery_d;
        bad_cnt_q      <= bad_cnt_d;
        fail_cnt_q     <= fail_cnt_d;
        held_status_q  <= held_status_d;
        usb_q          <= usb_d;
        chg_q          <= chg_d;
        ok_q           <= ok_d;
        batt_q         <= batt_d;
        volts_q        <= volts_d;
        pct_held_q     <= pct_held_d;
      end
      if (out_load) tick_cnt_q <= tick_cnt_q + 32'd1;
    end
  end

  // per-tick event and hold percent
  always_ff @(posedge clk_i) begin
    if (calc_en) begin
      event_q    <= event_d;
      hold_pct_q <= (down_q && hold_reached) ? PctFull : 7'd0;
    end else if (div_rsp.done) begin
      hold_pct_q <= div_rsp.quotient;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)                     out_valid_q <= 1'b0;
    else if (out_load)               out_valid_q <= 1'b1;
    else if (out_ready_i)            out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      o_event_q  <= event_q;
      o_hold_q   <= hold_pct_q;
      o_down_q   <= down_q;
      o_usb_q    <= usb_q;
      o_chg_q    <= chg_q;
      o_ok_q     <= ok_q;
      o_status_q <= held_status_q;
      o_mv_q     <= volts_q;
      o_bpct_q   <= pct_held_q;
      o_batt_q   <= batt_q;
      o_err_q    <= fail_cnt_q;
      o_seq_q    <= tick_cnt_q + 32'd1;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign event_kind_o      = o_event_q;
  assign hold_progress_o   = o_hold_q;
  assign button_pressed_o  = o_down_q;
  assign usb_attached_o    = o_usb_q;
  assign charging_o        = o_chg_q;
  assign status_ok_o       = o_ok_q;
  assign charger_status_o  = o_status_q;
  assign pack_mv_o         = o_mv_q;
  assign pack_charge_pct_o = o_bpct_q;
  assign pack_trusted_o    = o_batt_q;
  assign error_count_o     = o_err_q;
  assign sequence_res_o    = o_seq_q;

  // checks
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_DONE))
    else $error("result beat loaded outside the final state");

  a_hold_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> hold_progress_o <= PctFull)
    else $error("hold percent above 100");

  a_event_needs_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && event_kind_o != EV_NONE) |-> button_pressed_o)
    else $error("event reported with button up");

  a_bad_cnt_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bad_cnt_q <= BadLimit)
    else $error("bad sample count past saturation");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == S_DIV)
    else $error("divider finished outside the divide state");

endmodule

// ----- sim/pbm_checker.sv -----
// Watches the config bus and the tick and report channels of the power button
// and battery monitor, keeps its own copy of the monitor state, and compares
// every result beat with the oldest predicted report.
module pbm_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // config bus
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pbm_pkg::RegAddrW-1:0] paddr,
  input  logic [31:0]                  pwdata,
  input  logic [31:0]                  prdata,
  input  logic                         pready,
  // tick channel
  input  logic                         tick_valid_i,
  input  logic                         tick_ready_i,
  input  logic [31:0]                  now_ms_i,
  input  logic                         button_down_i,
  input  logic                         refresh_i,
  input  logic                         status_read_ok_i,
  input  logic [7:0]                   status_byte_i,
  input  logic                         battery_read_ok_i,
  input  logic [11:0]                  battery_adc_mv_i,
  // report channel
  input  logic                         report_valid_i,
  input  logic                         report_ready_i,
  input  logic [1:0]                   event_kind_i,
  input  logic [6:0]                   hold_progress_i,
  input  logic                         button_pressed_i,
  input  logic                         usb_attached_i,
  input  logic                         charging_i,
  input  logic                         status_ok_i,
  input  logic [7:0]                   charger_status_i,
  input  logic [12:0]                  pack_mv_i,
  input  logic [6:0]                   pack_charge_pct_i,
  input  logic                         pack_trusted_i,
  input  logic [31:0]                  error_count_i,
  input  logic [31:0]                  sequence_res_i,
  // status to the bench
  output int unsigned                  field_errors_o,
  output int unsigned                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import pbm_pkg::*;

  typedef struct packed {
    event_e      kind;
    logic [6:0]  hold_pct;
    logic        pressed;
    logic        usb;
    logic        chg;
    logic        poll_ok;
    logic [7:0]  status;
    logic [12:0] mv;
    logic [6:0]  pct;
    logic        batt_ok;
    logic [31:0] poll_fails;
    logic [31:0] ticks;
  } report_t;

  // register copies
  logic [15:0] hold_ms, batt_per, stat_per;

  // monitor state
  logic        press_on;
  logic [31:0] press_t0;
  logic        fired;
  logic [31:0] stat_t, batt_t;
  logic [2:0]  bad_run;
  logic [31:0] poll_fails, ticks;
  logic [7:0]  stat_byte;
  logic        usb, chg, poll_ok, batt_ok;
  logic [12:0] mv_held;
  logic [6:0]  pct_held;

  report_t due_reports[$];

  // Charge percent for a battery voltage, first knee at or below wins
  function automatic logic [6:0] mv_to_charge(logic [12:0] mv);
    int unsigned knee [9] = '{4200, 4100, 4000, 3900, 3800, 3700, 3600, 3500, 3400};
    int unsigned level [9] = '{100, 90, 80, 65, 50, 35, 20, 10, 5};
    for (int k = 0; k < 9; k++) begin
      if (mv >= knee[k]) return 7'(level[k]);
    end
    return 7'd0;
  endfunction

  function automatic int unsigned diff_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  task automatic clear_monitor();
    hold_ms    = HoldTimeRst;
    batt_per   = BatteryPeriodRst;
    stat_per   = StatusPeriodRst;
    press_on   = 1'b0;
    press_t0   = '0;
    fired      = 1'b0;
    stat_t     = '0;
    batt_t     = '0;
    bad_run    = '0;
    poll_fails = '0;
    ticks      = '0;
    stat_byte  = '0;
    usb        = 1'b0;
    chg        = 1'b0;
    poll_ok    = 1'b0;
    batt_ok    = 1'b0;
    mv_held    = '0;
    pct_held   = '0;
    due_reports.delete();
  endtask

  // One poll tick: hold timing, shutdown event, status poll, battery sample
  task automatic advance_monitor(output report_t r);
    logic [31:0] held;
    logic [63:0] ratio;
    logic [12:0] doubled;
    logic [1:0]  chg_state;
    logic        sample_good;
    r = '0;
    r.kind = EV_NONE;

    // button hold
    if (button_down_i) begin
      if (!press_on) begin
        press_on = 1'b1;
        press_t0 = now_ms_i;
      end
      held = now_ms_i - press_t0;
      if (hold_ms == 16'd0) begin
        r.hold_pct = PctFull;
      end else begin
        ratio = ({32'd0, held} * 64'd100) / {48'd0, hold_ms};
        r.hold_pct = (ratio > 64'd100) ? PctFull : ratio[6:0];
      end
      if (!fired && held >= {16'd0, hold_ms}) begin
        // the event re-reads the status byte when that read is good
        if (status_read_ok_i) begin
          stat_byte = status_byte_i;
          usb = status_byte_i[StUsbBit];
        end
        r.kind = usb ? EV_USB_BLOCKED : EV_SHUTDOWN;
        fired = 1'b1;
      end
    end else begin
      press_on = 1'b0;
      press_t0 = '0;
      fired = 1'b0;
    end

    // charger status poll
    if (refresh_i || (now_ms_i - stat_t) >= {16'd0, stat_per}) begin
      stat_t = now_ms_i;
      if (status_read_ok_i) begin
        chg_state = status_byte_i[StChgLo +: 2];
        stat_byte = status_byte_i;
        usb = status_byte_i[StUsbBit];
        chg = (chg_state == 2'd1) || (chg_state == 2'd2);
        poll_ok = 1'b1;
      end else begin
        poll_fails = poll_fails + 32'd1;
        poll_ok = 1'b0;
      end
    end

    // battery sample
    if ((now_ms_i - batt_t) >= {16'd0, batt_per}) begin
      doubled = {battery_adc_mv_i, 1'b0};
      batt_t = now_ms_i;
      sample_good = battery_read_ok_i && battery_adc_mv_i >= AdcMinMv &&
                    battery_adc_mv_i <= AdcMaxMv && doubled >= BatMinMv && doubled <= BatMaxMv;
      if (sample_good) begin
        mv_held = doubled;
        pct_held = mv_to_charge(doubled);
        batt_ok = 1'b1;
        bad_run = '0;
      end else begin
        if (bad_run < BadLimit) bad_run = bad_run + 3'd1;
        if (bad_run >= BadLimit) batt_ok = 1'b0;
      end
    end

    ticks = ticks + 32'd1;

    r.pressed    = button_down_i;
    r.usb        = usb;
    r.chg        = chg;
    r.poll_ok    = poll_ok;
    r.status     = stat_byte;
    r.mv         = mv_held;
    r.pct        = pct_held;
    r.batt_ok    = batt_ok;
    r.poll_fails = poll_fails;
    r.ticks      = ticks;
  endtask

  always @(posedge clk_i) begin : watch
    report_t     want;
    logic [31:0] want_rd;
    if (!rst_ni) begin
      clear_monitor();
      field_errors_o = 0;
    end else begin
      // config bus: track writes, check read data
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[3:2])
            REG_HOLD_TIME:      hold_ms = pwdata[15:0];
            REG_BATTERY_PERIOD: batt_per = pwdata[15:0];
            REG_STATUS_PERIOD:  stat_per = pwdata[15:0];
            default: ;
          endcase
        end else begin
          case (paddr[3:2])
            REG_HOLD_TIME:      want_rd = {16'd0, hold_ms};
            REG_BATTERY_PERIOD: want_rd = {16'd0, batt_per};
            REG_STATUS_PERIOD:  want_rd = {16'd0, stat_per};
            default:            want_rd = prdata;
          endcase
          field_errors_o += diff_field("prdata", want_rd, prdata);
        end
      end

      // result beat against the oldest prediction
      if (report_valid_i && report_ready_i) begin
        if (due_reports.size() == 0) begin
          $error("result beat with no tick outstanding");
          field_errors_o++;
        end else begin
          want = due_reports.pop_front();
          field_errors_o += diff_field("event_kind", 32'(want.kind), 32'(event_kind_i));
          field_errors_o += diff_field("hold_progress", 32'(want.hold_pct),
                                       32'(hold_progress_i));
          field_errors_o += diff_field("button_pressed", 32'(want.pressed),
                                       32'(button_pressed_i));
          field_errors_o += diff_field("usb_attached", 32'(want.usb), 32'(usb_attached_i));
          field_errors_o += diff_field("charging", 32'(want.chg), 32'(charging_i));
          field_errors_o += diff_field("status_ok", 32'(want.poll_ok), 32'(status_ok_i));
          field_errors_o += diff_field("charger_status", 32'(want.status),
                                       32'(charger_status_i));
          field_errors_o += diff_field("pack_mv", 32'(want.mv), 32'(pack_mv_i));
          field_errors_o += diff_field("pack_charge_pct", 32'(want.pct),
                                       32'(pack_charge_pct_i));
          field_errors_o += diff_field("pack_trusted", 32'(want.batt_ok),
                                       32'(pack_trusted_i));
          field_errors_o += diff_field("error_count", want.poll_fails, error_count_i);
          field_errors_o += diff_field("sequence_res", want.ticks, sequence_res_i);
        end
      end

      // accepted tick beat
      if (tick_valid_i && tick_ready_i) begin
        advance_monitor(want);
        due_reports.push_back(want);
      end
    end
    pending_o = due_reports.size();
  end

endmodule

// ----- sim/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pbm_pkg::*;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned ParkCycles   = 400;
  localparam int unsigned PhaseTicks   = 66;

  logic clk, rst_n;

  logic                psel, penable, pwrite, pready;
  logic [RegAddrW-1:0] paddr;
  logic [31:0]         pwdata, prdata;

  logic        in_valid, in_ready;
  logic [31:0] now_ms;
  logic        button_down, refresh, st_read_ok, bat_read_ok;
  logic [7:0]  st_byte;
  logic [11:0] bat_adc;

  logic        out_valid, out_ready;
  logic [1:0]  event_kind;
  logic [6:0]  hold_progress, pack_charge_pct;
  logic        button_pressed, usb_attached, charging, status_ok, pack_trusted;
  logic [7:0]  charger_status;
  logic [12:0] pack_mv;
  logic [31:0] error_count, sequence_res;

  int unsigned field_errors, pending;

  // stimulus bookkeeping
  logic [31:0] stamp_ms;
  logic [15:0] hold_cfg;
  logic        pressing, gaps_on, park_req;
  int unsigned run_left, burst_left, ticks_sent, settings_run, cycle_n;

  power_button_battery_monitor DUT (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .now_ms_i          (now_ms),
    .button_down_i     (button_down),
    .refresh_i         (refresh),
    .status_read_ok_i  (st_read_ok),
    .status_byte_i     (st_byte),
    .battery_read_ok_i (bat_read_ok),
    .battery_adc_mv_i  (bat_adc),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .event_kind_o      (event_kind),
    .hold_progress_o   (hold_progress),
    .button_pressed_o  (button_pressed),
    .usb_attached_o    (usb_attached),
    .charging_o        (charging),
    .status_ok_o       (status_ok),
    .charger_status_o  (charger_status),
    .pack_mv_o         (pack_mv),
    .pack_charge_pct_o (pack_charge_pct),
    .pack_trusted_o    (pack_trusted),
    .error_count_o     (error_count),
    .sequence_res_o    (sequence_res)
  );

  pbm_checker u_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .tick_valid_i      (in_valid),
    .tick_ready_i      (in_ready),
    .now_ms_i          (now_ms),
    .button_down_i     (button_down),
    .refresh_i         (refresh),
    .status_read_ok_i  (st_read_ok),
    .status_byte_i     (st_byte),
    .battery_read_ok_i (bat_read_ok),
    .battery_adc_mv_i  (bat_adc),
    .report_valid_i    (out_valid),
    .report_ready_i    (out_ready),
    .event_kind_i      (event_kind),
    .hold_progress_i   (hold_progress),
    .button_pressed_i  (button_pressed),
    .usb_attached_i    (usb_attached),
    .charging_i        (charging),
    .status_ok_i       (status_ok),
    .charger_status_i  (charger_status),
    .pack_mv_i         (pack_mv),
    .pack_charge_pct_i (pack_charge_pct),
    .pack_trusted_i    (pack_trusted),
    .error_count_i     (error_count),
    .sequence_res_i    (sequence_res),
    .field_errors_o    (field_errors),
    .pending_o         (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    cycle_n = 0;
    while (cycle_n < CycleLimit) begin
      @(posedge clk);
      cycle_n++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // result side: the stall pattern is redrawn at random; a toggle of
  // park_req holds ready low for a long stretch so the block backs up
  initial begin : receiver
    int unsigned mode, span;
    logic        park_seen;
    mode = 0;
    span = 0;
    park_seen = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (park_req != park_seen) begin
        out_ready <= 1'b0;
        repeat (ParkCycles) @(negedge clk);
        park_seen = park_req;
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = $urandom_range(20, 80);
        end
        span--;
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 3) != 0);
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ((span % 3) == 0);
        endcase
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'd0, val};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic read_reg(input logic [1:0] idx);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(input logic [15:0] hold, input logic [15:0] batt,
                            input logic [15:0] stat);
    write_reg(REG_HOLD_TIME, hold);
    write_reg(REG_BATTERY_PERIOD, batt);
    write_reg(REG_STATUS_PERIOD, stat);
    read_reg(REG_HOLD_TIME);
    read_reg(REG_BATTERY_PERIOD);
    read_reg(REG_STATUS_PERIOD);
    hold_cfg = hold;
    settings_run++;
  endtask

  // one tick beat; returns at the edge that accepts it
  task automatic drive_tick(input logic [31:0] t, input logic down, input logic rf,
                            input logic sok, input logic [7:0] sb, input logic bok,
                            input logic [11:0] adc);
    @(negedge clk);
    in_valid    <= 1'b1;
    now_ms      <= t;
    button_down <= down;
    refresh     <= rf;
    st_read_ok  <= sok;
    st_byte     <= sb;
    bat_read_ok <= bok;
    bat_adc     <= adc;
    do @(posedge clk); while (!in_ready);
    ticks_sent++;
  endtask

  // valid low with junk on the payload
  task automatic idle_for(input int unsigned n);
    repeat (n) begin
      @(negedge clk);
      in_valid    <= 1'b0;
      now_ms      <= $urandom;
      button_down <= $urandom_range(0, 1);
      refresh     <= $urandom_range(0, 1);
      st_byte     <= $urandom_range(0, 255);
      bat_adc     <= $urandom_range(0, 3300);
    end
  endtask

  // wait until every tick has its report, then let the block settle
  task automatic drain();
    idle_for(1);
    while (pending != 0) @(negedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // presses come as runs of down ticks with time moving in steps sized to the
  // hold time, now and then a full-range jump
  task automatic random_tick(input int unsigned step_max);
    logic [31:0] step;
    logic [11:0] adc;
    if (run_left == 0) begin
      pressing = !pressing;
      run_left = pressing ? $urandom_range(1, 12) : $urandom_range(1, 4);
    end
    run_left--;
    case ($urandom_range(0, 15))
      0:       step = $urandom;
      1:       step = '0;
      default: step = $urandom_range(0, step_max);
    endcase
    stamp_ms = stamp_ms + step;
    if ($urandom_range(0, 4) < 3) adc = 12'($urandom_range(1400, 2200));
    else adc = 12'($urandom_range(0, 3300));
    drive_tick(stamp_ms, pressing, $urandom_range(0, 5) == 0, $urandom_range(0, 4) != 0,
               8'($urandom_range(0, 255)), $urandom_range(0, 6) != 0, adc);
    // sender bursts
    if (gaps_on) begin
      if (burst_left == 0) begin
        idle_for($urandom_range(1, 8));
        burst_left = $urandom_range(1, 20);
      end else begin
        burst_left--;
      end
    end
  endtask

  initial begin : stimulus
    int unsigned step_max;
    rst_n       = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid    = 1'b0;
    now_ms      = '0;
    button_down = 1'b0;
    refresh     = 1'b0;
    st_read_ok  = 1'b0;
    st_byte     = '0;
    bat_read_ok = 1'b0;
    bat_adc     = '0;
    park_req    = 1'b0;
    pressing    = 1'b0;
    gaps_on     = 1'b0;
    run_left    = 0;
    burst_left  = 0;
    ticks_sent  = 0;
    settings_run = 0;
    hold_cfg    = HoldTimeRst;
    stamp_ms    = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed ticks under the reset register values
    drive_tick(32'd0,     1'b0, 1'b0, 1'b1, 8'h00, 1'b1, 12'd1800);
    drive_tick(32'd100,   1'b1, 1'b1, 1'b1, 8'h14, 1'b0, 12'd0);     // press, refresh
    drive_tick(32'd1600,  1'b1, 1'b0, 1'b1, 8'h10, 1'b0, 12'd0);     // half way
    drive_tick(32'd3100,  1'b1, 1'b0, 1'b1, 8'h04, 1'b1, 12'd2000);  // blocked by USB
    drive_tick(32'd3200,  1'b1, 1'b0, 1'b1, 8'h04, 1'b1, 12'd2000);  // no second event
    drive_tick(32'd3300,  1'b0, 1'b0, 1'b1, 8'h00, 1'b1, 12'd2000);
    drive_tick(32'd3400,  1'b1, 1'b1, 1'b0, 8'h00, 1'b1, 12'd2000);  // failed poll
    drive_tick(32'd6400,  1'b1, 1'b0, 1'b1, 8'h20, 1'b1, 12'd2000);  // shutdown
    drive_tick(32'd6500,  1'b1, 1'b0, 1'b0, 8'hFF, 1'b1, 12'd2000);
    drive_tick(32'd6600,  1'b0, 1'b0, 1'b0, 8'h00, 1'b1, 12'd2000);
    drive_tick(32'd7000,  1'b1, 1'b1, 1'b1, 8'h24, 1'b1, 12'd2000);
    drive_tick(32'd10000, 1'b1, 1'b0, 1'b0, 8'h00, 1'b1, 12'd2100);  // event on held USB
    drive_tick(32'd20000, 1'b0, 1'b0, 1'b1, 8'h30, 1'b1, 12'd1700);  // bottom of table
    drive_tick(32'd30000, 1'b0, 1'b0, 1'b1, 8'h00, 1'b1, 12'd249);   // ADC too low
    drive_tick(32'd40000, 1'b0, 1'b0, 1'b1, 8'h00, 1'b1, 12'd2801);  // ADC too high
    drive_tick(32'd50000, 1'b0, 1'b0, 1'b1, 8'h00, 1'b1, 12'd1399);  // doubled too low
    drive_tick(32'd60000, 1'b0, 1'b0, 1'b1, 8'h00, 1'b1, 12'd2201);  // doubled too high
    drive_tick(32'd70000, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0, 12'd2000);  // fifth bad sample
    drive_tick(32'd80000, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0, 12'd3300);  // count saturates
    drive_tick(32'd90000, 1'b0, 1'b0, 1'b1, 8'h00, 1'b1, 12'd1850);  // recovers
    drive_tick(32'hFFFF_FF00, 1'b1, 1'b0, 1'b1, 8'hC8, 1'b1, 12'd2100);
    drive_tick(32'h0000_0400, 1'b1, 1'b0, 1'b1, 8'h08, 1'b1, 12'd2100); // wrapped time
    drive_tick(32'h8000_0400, 1'b1, 1'b0, 1'b1, 8'h00, 1'b1, 12'd2100); // very long hold
    drive_tick(32'h8000_0401, 1'b0, 1'b1, 1'b1, 8'hFF, 1'b1, 12'd2100);
    drain();

    // random phases, each under its own register setting
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_config(16'd0, 16'd0, 16'd0);
        1: set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
        2: set_config(16'd1, 16'd1, 16'd1);
        3: set_config(HoldTimeRst, BatteryPeriodRst, StatusPeriodRst);
        default: set_config(16'($urandom_range(1, 400)), 16'($urandom_range(1, 600)),
                            16'($urandom_range(1, 200)));
      endcase
      if (ph == 0) begin
        // zero hold time and zero periods: event and polls on the first down tick
        drive_tick(32'd5000, 1'b1, 1'b0, 1'b1, 8'h00, 1'b1, 12'd1800);
        drive_tick(32'd5000, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 12'd1800);
      end
      stamp_ms = $urandom;
      step_max = hold_cfg / 3 + 2;
      gaps_on  = (ph != 2) && (ph != 5);
      if (ph == 3) park_req = ~park_req;
      repeat (PhaseTicks) random_tick(step_max);
      drain();
    end

    $display("Drove %0d ticks under %0d register settings (zero, full scale, one, reset,",
             ticks_sent, settings_run + 1);
    $display("random), with bursty input, receiver stalls and one long back-up.");
    if (field_errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
